// File: design/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the subset-sum decision block
// Transfer payloads, configuration decode and walk step types.
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int VALUE_W  = 16;
	localparam int TARGET_W = 21;
	localparam int SUM_W    = TARGET_W;

	// Configuration register index (word address paddr[2])
	localparam logic REG_TARGET_SUM = 1'b0;

	typedef struct packed {
		logic [VALUE_W-1:0] element_value;
		logic               last_element;
	} elem_t;

	typedef struct packed {
		logic found;
		logic overflowed;
	} res_t;

	// One Gray-code step on its way from the walker to the accumulator
	typedef struct packed {
		logic vld;
		logic add;
	} step_t;

endpackage

// File: design/subset_sum_exists_core.sv
// ----------------------------------------------------------------------------
// subset_sum_exists_core: subset-sum decision block
// Loads a set of elements, then walks every subset in Gray-code order.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-------------------------------
//  elem     | elem_valid / elem_ready          | sse_pkg::elem_t elem
//  res      | res_valid / res_ready            | sse_pkg::res_t res
//  config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
//  Elements are written straight into the element memory. A last element
//  starts the search: with n stored elements the walker issues 2^n - 1
//  memory reads, one per cycle, then the block drains the accumulator and
//  loads the result register, which waits out any output stall. The
//  memory's single read port sets the pace of the walk.
//  Reset clears the count, the overflow flag, the target and the result.
//  elem_ready is low from the last element until the result is loaded.
//
module subset_sum_exists_core #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// element channel
	input  logic                 elem_valid,
	output logic                 elem_ready,
	input  sse_pkg::elem_t       elem,
	// result channel
	output logic                 res_valid,
	input  logic                 res_ready,
	output sse_pkg::res_t        res,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 n_q;
	logic                          ovf_q;
	logic                          ovf_set_q;
	logic [sse_pkg::TARGET_W-1:0]  target_q;
	logic                          res_valid_q;
	sse_pkg::res_t                 res_q;

	logic                          elem_xfer;
	logic                          store_full;
	logic                          start;
	logic                          run;
	logic [CW-1:0]                 cnt_next;
	logic [AW-1:0]                 rd_addr;
	logic [sse_pkg::VALUE_W-1:0]   rd_data;
	sse_pkg::step_t                step_s1;
	logic                          at_end;
	logic                          found;
	logic                          cfg_wr;
	logic                          res_load;

	// ------------------------------------------------------------------
	// Configuration: one register, target_sum at byte address 0
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr && (paddr[2] == sse_pkg::REG_TARGET_SUM)) begin
			target_q <= pwdata[sse_pkg::TARGET_W-1:0];
		end
	end

	assign prdata = (paddr[2] == sse_pkg::REG_TARGET_SUM) ? 32'(target_q) : '0;

	// ------------------------------------------------------------------
	// Loading: accept elements only while idle, drop those past the store
	// ------------------------------------------------------------------
	assign elem_ready = (state_q == ST_IDLE);
	assign elem_xfer  = elem_valid && elem_ready;
	assign store_full = (cnt_q == CW'(MAX_ELEMENTS));
	assign cnt_next   = store_full ? cnt_q : cnt_q + CW'(1);
	assign start      = elem_xfer && elem.last_element;
	assign run        = (state_q == ST_WALK);

	// Load the result register once the previous result has left
	assign res_load   = (state_q == ST_REPORT) && (!res_valid_q || res_ready);

	sse_store #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (elem_xfer && !store_full),
		.waddr (cnt_q[AW-1:0]),
		.wdata (elem.element_value),
		.re    (run),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Walker issues one read per cycle; read data and step are registered before the accumulator consumes them
	sse_walk #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.AW           (AW),
		.CW           (CW)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.run     (run),
		.n       (n_q),
		.rd_addr (rd_addr),
		.step_s1 (step_s1),
		.at_end  (at_end)
	);

	sse_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.target  (target_q),
		.step_s1 (step_s1),
		.rd_data (rd_data),
		.found   (found)
	);

	// ------------------------------------------------------------------
	// Control: load, walk, drain the last step, hand off the result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			ovf_set_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// load a fresh result, or drop the old one once the consumer takes it
			if (res_load) begin
				res_q.found      <= found;
				res_q.overflowed <= ovf_set_q;
				res_valid_q      <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (elem_xfer) begin
						if (elem.last_element) begin
							// latch set size and overflow, clear for the next set
							n_q       <= cnt_next;
							ovf_set_q <= ovf_q | store_full;
							cnt_q     <= '0;
							ovf_q     <= 1'b0;
							state_q   <= ST_WALK;
						end else begin
							cnt_q <= cnt_next;
							ovf_q <= ovf_q | store_full;
						end
					end
				end
				ST_WALK: begin
					if (at_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					// hold until the result register is free
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// Element count never runs past the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ELEMENTS))
		else $error("element count exceeds store depth");

	// The walk reads only loaded entries
	a_rd_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> (CW'(rd_addr) < n_q))
		else $error("walk reads an entry outside the loaded set");

	// A last-element transfer starts a walk with a cleared count
	a_start_walk: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_WALK) && (cnt_q == '0) && !ovf_q)
		else $error("last element did not start the walk");

	// The drain cycle always carries the final step of the walk
	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> step_s1.vld)
		else $error("drain without a pending step");
`endif

endmodule

// File: design/sse_store.sv
// ----------------------------------------------------------------------------
// sse_store: element memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sse_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [sse_pkg::VALUE_W-1:0]  wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [sse_pkg::VALUE_W-1:0]  rdata
);

	logic [sse_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [sse_pkg::VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/sse_walk.sv
// ----------------------------------------------------------------------------
// sse_walk: Gray-code subset walker
// Counts steps, picks the element that flips and whether it joins or leaves.
// ----------------------------------------------------------------------------
module sse_walk #(
	parameter int MAX_ELEMENTS = 16,
	parameter int AW           = 4,
	parameter int CW           = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               run,
	input  logic [CW-1:0]      n,
	output logic [AW-1:0]      rd_addr,
	output sse_pkg::step_t     step_s1,
	output logic               at_end
);

	localparam int KW = MAX_ELEMENTS + 1;

	logic [KW-1:0] k_q;
	logic [KW-1:0] end_mask;
	logic          add;

	// Flipped bit is the lowest set bit of k; it joins if bit above is clear
	always_comb begin
		rd_addr = '0;
		add     = 1'b0;
		for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
			if (k_q[i]) begin
				rd_addr = AW'(i);
				add     = ~k_q[i+1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KW; i++) begin
			end_mask[i] = (CW'(i) < n);
		end
	end

	assign at_end = run && (k_q == end_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			step_s1 <= '0;
		end else begin
			if (start) begin
				k_q <= KW'(1);
			end else if (run) begin
				k_q <= k_q + KW'(1);
			end
			step_s1.vld <= run;
			step_s1.add <= add;
		end
	end

endmodule

// File: design/sse_accum.sv
// ----------------------------------------------------------------------------
// sse_accum: running subset sum and match flag
// Add or drop one element per step and compare against the target.
// ----------------------------------------------------------------------------
module sse_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sse_pkg::TARGET_W-1:0]  target,
	input  sse_pkg::step_t                step_s1,
	input  logic [sse_pkg::VALUE_W-1:0]   rd_data,
	output logic                          found
);

	logic [sse_pkg::SUM_W-1:0] sum_q;
	logic [sse_pkg::SUM_W-1:0] sum_next;
	logic [sse_pkg::SUM_W-1:0] value_ext;
	logic                      found_q;

	assign value_ext = sse_pkg::SUM_W'(rd_data);
	assign sum_next  = step_s1.add ? sum_q + value_ext : sum_q - value_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			sum_q   <= '0;
			found_q <= (target == '0);
		end else if (step_s1.vld) begin
			sum_q   <= sum_next;
			found_q <= found_q | (sum_next == target);
		end
	end

	assign found = found_q;

endmodule

// File: tb/subset_sum_exists_core_tb.sv
// ----------------------------------------------------------------------------
// subset_sum_exists_core_tb: self-checking bench of the subset-sum block
// Streams sets of elements with random gaps and result stalls, predicts
// each found/overflowed verdict by walking all subsets of the stored set,
// and programs the target over the APB port between sets of tests.
// ----------------------------------------------------------------------------
module subset_sum_exists_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ELEMENTS = 16;
	localparam int VALUE_MAX = 65535;
	localparam int TARGET_W = sse_pkg::TARGET_W;
	localparam logic [TARGET_W-1:0] TARGET_TOP = '1;
	// Register map: the target register and one unused word slot
	localparam logic [2:0] TARGET_ADDR = {sse_pkg::REG_TARGET_SUM, 2'b00};
	localparam logic [2:0] SPARE_ADDR = {~sse_pkg::REG_TARGET_SUM, 2'b00};
	// Cycles with no transfer at all before the run is declared hung. The
	// slowest legal stretch is a full 16-element walk plus the longest output
	// stall and input gap; allow several times that.
	localparam int HANG_LIMIT = 300000;
	// Settle time for element writes that cause no result
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;
	logic elem_valid;
	logic elem_ready;
	sse_pkg::elem_t elem;
	logic res_valid;
	logic res_ready = 1'b0;
	sse_pkg::res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the block state, advanced on every accepted element
	logic [TARGET_W-1:0] goal_sum;
	logic [sse_pkg::VALUE_W-1:0] stored_vals [MAX_ELEMENTS];
	int unsigned stored_count;
	bit dropped_any;

	// Verdicts owed by the block, oldest first
	sse_pkg::res_t verdicts_due [$];
	int mismatches = 0;
	// When set, both sides run back to back with no idling
	bit steady = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;

	subset_sum_exists_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.elem_valid(elem_valid),
		.elem_ready(elem_ready),
		.elem(elem),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Idle length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// True if some subset of the stored elements (empty one included) adds up
	// to the goal. Walk every subset; sets are at most 16 deep.
	function automatic bit subset_reaches();
		int unsigned total;
		for (int unsigned mask = 0; mask < (32'd1 << stored_count); mask++) begin
			total = 0;
			for (int b = 0; b < stored_count; b++)
				if (mask[b])
					total += stored_vals[b];
			if (total == goal_sum)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the shadow state by one accepted element
	function automatic void note_element(logic [15:0] v, logic last);
		sse_pkg::res_t verdict;
		if (stored_count < MAX_ELEMENTS) begin
			stored_vals[stored_count] = v;
			stored_count++;
		end else begin
			// store full: drop the element, remember it
			dropped_any = 1'b1;
		end
		if (last) begin
			verdict.found = subset_reaches();
			verdict.overflowed = dropped_any;
			verdicts_due.insert(verdicts_due.size(), verdict);
			stored_count = 0;
			dropped_any = 1'b0;
		end
	endfunction

	// Send one element, then return at the edge that accepted it. Valid stays
	// high into the next call; only a gap or quiesce() lowers it.
	task automatic send_element(input logic [15:0] v, input logic last);
		int gap;
		sse_pkg::elem_t item;
		gap = pick_gap();
		item.element_value = v;
		item.last_element = last;
		@(negedge clk);
		if (gap > 0) begin
			elem_valid <= 1'b0;
			elem <= sse_pkg::elem_t'($urandom);
			repeat (gap) @(negedge clk);
		end
		elem_valid <= 1'b1;
		elem <= item;
		do @(posedge clk); while (!elem_ready);
		note_element(v, last);
	endtask

	// Drop valid, wait for every owed verdict, then let trailing writes settle
	task automatic quiesce();
		@(negedge clk);
		elem_valid <= 1'b0;
		elem <= sse_pkg::elem_t'($urandom);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access cycle. Reads of the target
	// register are checked against the shadow copy.
	task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			// unknown register slots ignore the write; the target keeps 21 bits
			if (addr[2] == sse_pkg::REG_TARGET_SUM)
				goal_sum = data[TARGET_W-1:0];
		end else if (addr[2] == sse_pkg::REG_TARGET_SUM && prdata[TARGET_W-1:0] !== goal_sum) begin
			$error("target_sum: expected %0d, got %0d", goal_sum, prdata[TARGET_W-1:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Send a whole set; the final element carries the last flag
	task automatic send_set(input logic [15:0] vals [MAX_ELEMENTS + 1], input int n);
		for (int i = 0; i < n; i++)
			send_element(vals[i], i == n - 1);
	endtask

	// Reset target is zero: the empty subset always matches
	task automatic test_zero_target();
		reg_access(1'b0, TARGET_ADDR, '0);
		send_element(16'hFFFF, 1'b1);
		send_element(16'h0000, 1'b1);
		quiesce();
	endtask

	// Masking of wide writes, ignored writes to an unused slot, readback
	task automatic test_register_access();
		reg_access(1'b1, TARGET_ADDR, 32'hFFFF_FFFF);
		reg_access(1'b0, TARGET_ADDR, '0);
		reg_access(1'b1, SPARE_ADDR, 32'h0000_0064);
		reg_access(1'b0, TARGET_ADDR, '0);
		// largest target lies out of reach of two maximum elements
		send_element(16'hFFFF, 1'b0);
		send_element(16'hFFFF, 1'b1);
		quiesce();
	endtask

	// Exact hit, near miss, and a zero element that adds no sums
	task automatic test_exact_sums();
		reg_access(1'b1, TARGET_ADDR, 32'd100);
		send_element(16'd100, 1'b1);
		send_element(16'd99, 1'b1);
		send_element(16'd60, 1'b0);
		send_element(16'd0, 1'b0);
		send_element(16'd30, 1'b0);
		send_element(16'd10, 1'b1);
		quiesce();
	endtask

	// Fill the store, then send a last element that has to be dropped. Only
	// the dropped element could make the target, so the verdict is a miss
	// with overflow set.
	task automatic test_store_full();
		reg_access(1'b1, TARGET_ADDR, 32'd5);
		for (int i = 0; i < MAX_ELEMENTS - 1; i++)
			send_element(16'hFFFF, 1'b0);
		send_element(16'd1, 1'b0);
		send_element(16'd5, 1'b1);
		quiesce();
	endtask

	// One random element, biased by the size of the target
	function automatic logic [15:0] random_value(input logic [TARGET_W-1:0] tgt);
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		if (tgt <= 255 && r < 6)
			return 16'($urandom_range(0, tgt));
		return 16'($urandom_range(0, VALUE_MAX));
	endfunction

	// Random sets under one target. Half of the sets that can hold the
	// target get a planted subset that sums to it exactly.
	task automatic run_random_phase(input logic [TARGET_W-1:0] tgt, input int items);
		logic [15:0] vals [MAX_ELEMENTS + 1];
		logic [15:0] swap;
		int sent, n, m, r, k;
		int unsigned rem, lo, hi, part;
		reg_access(1'b1, TARGET_ADDR, 32'(tgt));
		reg_access(1'b0, TARGET_ADDR, '0);
		sent = 0;
		while (sent < items) begin
			steady = ($urandom_range(0, 4) == 0);
			// most sets small to keep walks short; rarely one of 13 up to 16 elements
			r = $urandom_range(0, 39);
			if (r < 26)
				n = $urandom_range(1, 5);
			else if (r < 36)
				n = $urandom_range(6, 9);
			else if (r < 39)
				n = $urandom_range(10, 12);
			else
				n = $urandom_range(13, MAX_ELEMENTS);
			for (int i = 0; i < n; i++)
				vals[i] = random_value(tgt);
			m = (tgt + VALUE_MAX - 1) / VALUE_MAX;
			if (tgt != 0 && m <= n && $urandom_range(0, 1) == 1) begin
				rem = tgt;
				for (int j = 0; j < m; j++) begin
					lo = (rem > VALUE_MAX * (m - 1 - j)) ? rem - VALUE_MAX * (m - 1 - j) : 0;
					hi = (rem < VALUE_MAX) ? rem : VALUE_MAX;
					part = $urandom_range(hi, lo);
					vals[j] = 16'(part);
					rem -= part;
				end
				// scatter the planted parts
				for (int j = 0; j < n; j++) begin
					k = $urandom_range(0, n - 1);
					swap = vals[j];
					vals[j] = vals[k];
					vals[k] = swap;
				end
			end
			send_set(vals, n);
			sent += n;
		end
		steady = 1'b0;
		quiesce();
	endtask

	task automatic test_random_sets();
		run_random_phase(TARGET_W'($urandom_range(1, 255)), 28);
		run_random_phase(TARGET_W'($urandom_range(256, VALUE_MAX)), 28);
		run_random_phase(TARGET_W'($urandom_range(VALUE_MAX + 1, 600000)), 28);
		run_random_phase(TARGET_TOP, 28);
	endtask

	// Output side: hold ready low for a random stall, then release it
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Compare every result transfer with the oldest owed verdict
	always @(posedge clk) begin : check_results
		sse_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected result transfer: found %0b, overflowed %0b",
					res.found, res.overflowed);
				mismatches++;
			end else begin
				want = verdicts_due.pop_front();
				if (res.found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, res.found);
					mismatches++;
				end
				if (res.overflowed !== want.overflowed) begin
					$error("overflowed: expected %0b, got %0b",
						want.overflowed, res.overflowed);
					mismatches++;
				end
			end
		end
	end

	// Hang detection: count cycles with no transfer on any port
	always @(posedge clk) begin
		if ((elem_valid && elem_ready) || (res_valid && res_ready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		elem_valid = 1'b0;
		elem = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		goal_sum = '0;
		stored_count = 0;
		dropped_any = 1'b0;
		foreach (stored_vals[i])
			stored_vals[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_zero_target();
		test_register_access();
		test_exact_sums();
		test_store_full();
		test_random_sets();

		// all verdicts are in; quiesce once more so the block has a chance to misbehave
		quiesce();
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
